FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/dqbs_pkg.sv
package dqbs_pkg;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CONTAINS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd3;

  // Which logical slot the store read port looks at.
  typedef enum logic [1:0] {
    RD_SCAN  = 2'd0,
    RD_SHIFT = 2'd1,
    RD_FRONT = 2'd2,
    RD_BACK  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    load_op;
    logic    exec;
    logic    idx_clr;
    logic    idx_inc;
    rd_sel_t rd_sel;
    logic    shift_wr;
    logic    dec_cnt;
    logic    set_found;
    logic    no_match;
    logic    cap_front;
    logic    cap_back;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic is_remove;
    logic empty;
    logic match;
    logic idx_last;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/dqbs_ram.sv
module dqbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/dqbs_ctrl.sv
module dqbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dqbs_pkg::sts_t    sts,
  output dqbs_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_EXEC      = 10'b0000000010,
    S_SCAN_RD   = 10'b0000000100,
    S_SCAN_CMP  = 10'b0000001000,
    S_SHIFT_RD  = 10'b0000010000,
    S_SHIFT_WR  = 10'b0000100000,
    S_FRONT_RD  = 10'b0001000000,
    S_BACK_RD   = 10'b0010000000,
    S_BACK_CAP  = 10'b0100000000,
    S_FIN       = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = dqbs_pkg::RD_SCAN;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_search && !sts.empty) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN_RD;
        end else begin
          state_next = S_FRONT_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_sel = dqbs_pkg::RD_SCAN;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          cmd.set_found = 1'b1;
          if (sts.is_remove && sts.idx_last) begin
            cmd.dec_cnt = 1'b1;
            state_next  = S_FRONT_RD;
          end else if (sts.is_remove) begin
            state_next = S_SHIFT_RD;
          end else begin
            state_next = S_FRONT_RD;
          end
        end else if (sts.idx_last) begin
          cmd.no_match = sts.is_remove;
          state_next   = S_FRONT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_sel = dqbs_pkg::RD_SHIFT;
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        if (sts.shift_last) begin
          cmd.dec_cnt = 1'b1;
          state_next  = S_FRONT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SHIFT_RD;
        end
      end
      S_FRONT_RD: begin
        cmd.rd_sel = dqbs_pkg::RD_FRONT;
        state_next = sts.empty ? S_FIN : S_BACK_RD;
      end
      S_BACK_RD: begin
        cmd.rd_sel    = dqbs_pkg::RD_BACK;
        cmd.cap_front = 1'b1;
        state_next    = S_BACK_CAP;
      end
      S_BACK_CAP: begin
        cmd.cap_back = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/dqbs_dp.sv
module dqbs_dp #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [dqbs_pkg::MODE_W-1:0]          mode,
  input  logic signed [dqbs_pkg::VALUE_W-1:0]  value,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [dqbs_pkg::STATUS_W-1:0]        status,
  output logic                                 found,
  output logic signed [dqbs_pkg::VALUE_W-1:0]  front_value,
  output logic signed [dqbs_pkg::VALUE_W-1:0]  back_value,
  output logic [dqbs_pkg::COUNT_W-1:0]         entry_count,
  output logic                                 is_empty,
  input  dqbs_pkg::cmd_t                       cmd,
  output dqbs_pkg::sts_t                       sts
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + 1;
  localparam int VW = dqbs_pkg::VALUE_W;
  localparam logic [AW:0]   CAP_EXT  = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST     = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  logic [AW-1:0]                 head;
  logic [CW-1:0]                 cnt;
  logic [AW-1:0]                 idx;
  logic [dqbs_pkg::MODE_W-1:0]   op_mode;
  logic [DATA_WIDTH-1:0]         op_val;
  logic [DATA_WIDTH-1:0]         in_val;
  logic [dqbs_pkg::STATUS_W-1:0] res_status;
  logic                          res_found;
  logic [DATA_WIDTH-1:0]         front_r;
  logic [DATA_WIDTH-1:0]         back_r;
  logic [VW-1:0]                 front_ext;
  logic [VW-1:0]                 back_ext;
  logic [CW+dqbs_pkg::COUNT_W-1:0] cnt_wide;

  logic                  full;
  logic                  empty;
  logic                  push_ok;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         rd_logical;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;

  function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= CAP_EXT) ? s - CAP_EXT : s;
    return t[AW-1:0];
  endfunction

  // Incoming values are zero-extended or truncated to the stored width.
  if (DATA_WIDTH > VW) begin : g_val_wide
    assign in_val = {{(DATA_WIDTH - VW){1'b0}}, value};
  end else begin : g_val_narrow
    assign in_val = value[DATA_WIDTH-1:0];
  end

  // Results are sign-extended from the stored width, or truncated to the value width when the store is wider.
  if (DATA_WIDTH >= VW) begin : g_out_wide
    assign front_ext = front_r[VW-1:0];
    assign back_ext  = back_r[VW-1:0];
  end else begin : g_out_narrow
    assign front_ext = {{(VW - DATA_WIDTH){front_r[DATA_WIDTH-1]}}, front_r};
    assign back_ext  = {{(VW - DATA_WIDTH){back_r[DATA_WIDTH-1]}}, back_r};
  end

  assign full     = (cnt == CAP_CNT);
  assign empty    = (cnt == '0);
  assign cnt_m1   = cnt - 1'b1;
  assign head_dec = (head == '0) ? LAST : head - 1'b1;
  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign push_ok  = cmd.exec && !full &&
                    ((op_mode == dqbs_pkg::MODE_PUSH_FRONT) ||
                     (op_mode == dqbs_pkg::MODE_PUSH_BACK));

  always_comb begin
    case (cmd.rd_sel)
      dqbs_pkg::RD_SCAN:  rd_logical = idx;
      dqbs_pkg::RD_SHIFT: rd_logical = idx + 1'b1;
      dqbs_pkg::RD_FRONT: rd_logical = '0;
      dqbs_pkg::RD_BACK:  rd_logical = cnt_m1[AW-1:0];
      default:            rd_logical = '0;
    endcase
  end

  assign rd_addr = wrap_addr({1'b0, head} + {1'b0, rd_logical});

  always_comb begin
    wr_en   = push_ok || cmd.shift_wr;
    wr_data = cmd.shift_wr ? rd_data : op_val;
    if (cmd.shift_wr) begin
      wr_addr = wrap_addr({1'b0, head} + {1'b0, idx});
    end else if (op_mode == dqbs_pkg::MODE_PUSH_FRONT) begin
      wr_addr = head_dec;
    end else begin
      wr_addr = wrap_addr({1'b0, head} + (AW + 1)'(cnt));
    end
  end

  dqbs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Operation registers and the working copy of the result.
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_mode <= mode;
      op_val  <= in_val;
    end
    if (cmd.exec) begin
      res_found <= 1'b0;
      case (op_mode)
        dqbs_pkg::MODE_PUSH_FRONT,
        dqbs_pkg::MODE_PUSH_BACK: begin
          res_status <= full ? dqbs_pkg::ST_PUSH_FULL : dqbs_pkg::ST_OK;
        end
        dqbs_pkg::MODE_POP_FRONT,
        dqbs_pkg::MODE_POP_BACK: begin
          res_status <= empty ? dqbs_pkg::ST_POP_EMPTY : dqbs_pkg::ST_OK;
        end
        dqbs_pkg::MODE_REMOVE: begin
          res_status <= empty ? dqbs_pkg::ST_NO_MATCH : dqbs_pkg::ST_OK;
        end
        default: begin
          res_status <= dqbs_pkg::ST_OK;
        end
      endcase
    end
    if (cmd.set_found) begin
      res_found <= 1'b1;
    end
    if (cmd.no_match) begin
      res_status <= dqbs_pkg::ST_NO_MATCH;
    end
    if (cmd.cap_front) begin
      front_r <= rd_data;
    end
    if (cmd.cap_back) begin
      back_r <= rd_data;
    end
  end

  // Queue pointers, occupancy and the scan index.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
      idx  <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.exec) begin
        case (op_mode)
          dqbs_pkg::MODE_PUSH_FRONT: begin
            if (!full) begin
              head <= head_dec;
              cnt  <= cnt + 1'b1;
            end
          end
          dqbs_pkg::MODE_PUSH_BACK: begin
            if (!full) begin
              cnt <= cnt + 1'b1;
            end
          end
          dqbs_pkg::MODE_POP_FRONT: begin
            if (!empty) begin
              head <= head_inc;
              cnt  <= cnt_m1;
            end
          end
          dqbs_pkg::MODE_POP_BACK: begin
            if (!empty) begin
              cnt <= cnt_m1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.dec_cnt) begin
        cnt <= cnt_m1;
      end
    end
  end

  // Output register.
  assign cnt_wide = {{dqbs_pkg::COUNT_W{1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      found       <= res_found;
      front_value <= empty ? '0 : front_ext;
      back_value  <= empty ? '0 : back_ext;
      entry_count <= cnt_wide[dqbs_pkg::COUNT_W-1:0];
      is_empty    <= empty;
    end
  end

  always_comb begin
    sts.is_search  = (op_mode == dqbs_pkg::MODE_CONTAINS) ||
                     (op_mode == dqbs_pkg::MODE_REMOVE);
    sts.is_remove  = (op_mode == dqbs_pkg::MODE_REMOVE);
    sts.empty      = empty;
    sts.match      = (rd_data == op_val);
    sts.idx_last   = (EW'(idx) + EW'(1) == EW'(cnt));
    sts.shift_last = (EW'(idx) + EW'(2) == EW'(cnt));
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

FILE: rtl/core/deque_bag_with_search_core.sv
// Each operation runs through the states idle (load), execute, front read, back read, back
// capture and finish (the back read and capture are skipped when the queue is empty afterward);
// a search adds a read and a compare per entry examined, a removal a read and a write per
// entry moved up. One item is handled at a time; the single read port of the store and the
// scan through it set the pace. Reset (rst, synchronous, active high) empties the queue and
// drops any held result; the store itself is not cleared and needs no clearing pass.
module deque_bag_with_search_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input channel: one operation per beat.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dqbs_pkg::MODE_W-1:0]          mode,
  input  logic signed [dqbs_pkg::VALUE_W-1:0]  value,
  // Output channel: one result per beat.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dqbs_pkg::STATUS_W-1:0]        status,
  output logic                                 found,
  output logic signed [dqbs_pkg::VALUE_W-1:0]  front_value,
  output logic signed [dqbs_pkg::VALUE_W-1:0]  back_value,
  output logic [dqbs_pkg::COUNT_W-1:0]         entry_count,
  output logic                                 is_empty
);

  // The entries live in a circular buffer: a head pointer marks the front and
  // the occupancy count marks the back, so pushes and pops at either end touch
  // at most one slot. Membership tests walk the buffer from the front one
  // entry at a time. A removal first finds the entry, then moves every later
  // entry one slot toward the front (read one, write one) to close the gap.
  //
  // After an operation that leaves entries, the front and back slots are read back so that the
  // result carries them. The result sits in an output register, so a new input
  // beat can be taken while the previous result still waits for its receiver;
  // only the final load of the next result waits for that register to drain.

  dqbs_pkg::cmd_t cmd;
  dqbs_pkg::sts_t sts;

  // The controller sequences each operation through its states, driving the store.
  dqbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the store, the pointers and the output register.
  dqbs_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .value       (value),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .found       (found),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

FILE: rtl/core/dqbs_checker.sv
`include "assert_macros.svh"

module dqbs_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [dqbs_pkg::STATUS_W-1:0]        status,
  input logic                                 found,
  input logic signed [dqbs_pkg::VALUE_W-1:0]  front_value,
  input logic signed [dqbs_pkg::VALUE_W-1:0]  back_value,
  input logic [dqbs_pkg::COUNT_W-1:0]         entry_count,
  input logic                                 is_empty
);

  // An empty queue reports zero at both ends.
  `ASSERT_IMPLIES(a_empty_ends_zero, clk, rst, out_valid && is_empty, front_value == 0 && back_value == 0)

  // A nonzero count never comes with the empty flag.
  `ASSERT_IMPLIES(a_count_not_empty, clk, rst, out_valid && entry_count != 0, !is_empty)

  // A match always comes with a good status.
  `ASSERT_IMPLIES(a_found_ok, clk, rst, out_valid && found, status == dqbs_pkg::ST_OK)

  // A pop that failed for lack of entries leaves the queue empty.
  `ASSERT_IMPLIES(a_pop_empty, clk, rst, out_valid && status == dqbs_pkg::ST_POP_EMPTY, is_empty && !found)

  // A held result beat keeps its contents.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(front_value) && $stable(status))

endmodule

bind deque_bag_with_search_core dqbs_checker u_dqbs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .found       (found),
  .front_value (front_value),
  .back_value  (back_value),
  .entry_count (entry_count),
  .is_empty    (is_empty)
);
